[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a given clock and active-low reset
`define BVM_ASSERT_CR(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (prop)) \
		else $error("bvm check failed");

// concurrent check on the block clock and reset
`define BVM_ASSERT(lbl, prop) `BVM_ASSERT_CR(lbl, clk, arst_n, prop)

`endif

[rtl/core/bvm_pkg.sv]
package bvm_pkg;

	localparam int DEF_NUM_REGS    = 16;
	localparam int DEF_ZF_INDEX    = 12;
	localparam int DEF_CF_INDEX    = 13;
	localparam int DEF_OF_INDEX    = 14;
	localparam int DEF_PC_INDEX    = 15;
	localparam int DEF_STACK_DEPTH = 64;

	typedef logic [7:0] byte_t;

	typedef enum logic [3:0] {
		OP_MOV   = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_CMP   = 4'd4,
		OP_PUSH  = 4'd5,
		OP_POP   = 4'd6,
		OP_JMP   = 4'd7,
		OP_BE    = 4'd8,
		OP_BNE   = 4'd9,
		OP_PRINT = 4'd10
	} func_t;

	typedef enum logic [1:0] {
		KD_RR  = 2'd0,
		KD_RI  = 2'd1,
		KD_REG = 2'd2,
		KD_IMM = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_KIND  = 3'd1,
		ST_FULL  = 3'd2,
		ST_EMPTY = 3'd3,
		ST_REG   = 3'd4
	} status_t;

	// one write into a memory, also kept for forwarding
	typedef struct packed {
		logic  we;
		byte_t addr;
		byte_t data;
	} wr_port_t;

	typedef struct packed {
		logic  dest_we;
		logic  flag_we;
		byte_t res;
		logic  zf;
		logic  cf;
		logic  of;
	} alu_out_t;

endpackage

[rtl/core/bvm_alu.sv]
module bvm_alu (
	input  logic [3:0]         func,
	input  bvm_pkg::byte_t     x,
	input  bvm_pkg::byte_t     y,
	output bvm_pkg::alu_out_t  res
);
	import bvm_pkg::*;

	logic [8:0]  sum;
	byte_t       dif;
	logic [15:0] prod;

	always_comb begin
		sum  = {1'b0, x} + {1'b0, y};
		dif  = x - y;
		prod = x * y;
		res  = '0;
		unique case (func) inside
			OP_MOV: begin
				res.dest_we = 1'b1;
				res.res     = y;
			end
			OP_ADD: begin
				res.dest_we = 1'b1;
				res.flag_we = 1'b1;
				res.res     = sum[7:0];
				res.zf      = (sum[7:0] == 8'd0);
				res.cf      = sum[8];
				res.of      = (x[7] ^ sum[7]) & (y[7] ^ sum[7]);
			end
			OP_SUB: begin
				res.dest_we = 1'b1;
				res.flag_we = 1'b1;
				res.res     = dif;
				res.zf      = (dif == 8'd0);
				res.cf      = (x < y);
				res.of      = (x[7] ^ y[7]) & (x[7] ^ dif[7]);
			end
			OP_MUL: begin
				res.dest_we = 1'b1;
				res.res     = prod[7:0];
			end
			OP_CMP: begin
				res.flag_we = 1'b1;
				res.zf      = (x == y);
				res.cf      = ($signed(x) > $signed(y));
				res.of      = ($signed(x) < $signed(y));
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/bvm_regfile.sv]
module bvm_regfile #(
	parameter int NUM_REGS = bvm_pkg::DEF_NUM_REGS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  bvm_pkg::byte_t    raddr_a,
	input  bvm_pkg::byte_t    raddr_b,
	input  bvm_pkg::wr_port_t wr,
	output bvm_pkg::byte_t    rdata_a,
	output bvm_pkg::byte_t    rdata_b
);
	import bvm_pkg::*;

	localparam int IDX_W = $clog2(NUM_REGS);

	byte_t               mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	byte_t               rdata_a_q;
	byte_t               rdata_b_q;
	logic [IDX_W-1:0]    ia;
	logic [IDX_W-1:0]    ib;
	logic [IDX_W-1:0]    iw;
	logic                a_in;
	logic                b_in;

	assign ia   = raddr_a[IDX_W-1:0];
	assign ib   = raddr_b[IDX_W-1:0];
	assign iw   = wr.addr[IDX_W-1:0];
	assign a_in = ({1'b0, raddr_a} < 9'(NUM_REGS));
	assign b_in = ({1'b0, raddr_b} < 9'(NUM_REGS));

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.we) begin
			vld_q[iw] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[iw] <= wr.data;
		end
		if (rd_en) begin
			rdata_a_q <= (a_in && vld_q[ia]) ? mem[ia] : 8'd0;
			rdata_b_q <= (b_in && vld_q[ib]) ? mem[ib] : 8'd0;
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

[rtl/core/bvm_stack.sv]
module bvm_stack #(
	parameter int STACK_DEPTH = bvm_pkg::DEF_STACK_DEPTH
) (
	input  logic              clk,
	input  logic              rd_en,
	input  bvm_pkg::byte_t    raddr,
	input  bvm_pkg::wr_port_t wr,
	output bvm_pkg::byte_t    rdata
);
	import bvm_pkg::*;

	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	byte_t mem [STACK_DEPTH];
	byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr[ADDR_W-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr[ADDR_W-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/byte_vm_instruction_execute_core.sv]
// pipeline: stage-1 register, then output register; one word per cycle
// unless out_stall holds the output; register file and stack reads are issued
// at accept; alu result and write-back land, with forwarding, on leaving stage 1
// reset: arst_n clears the register file (through valid bits), flags, pc and
// stack count at once; no clearing pass, stack contents undefined until pushed
module byte_vm_instruction_execute_core #(
	parameter int NUM_REGS    = bvm_pkg::DEF_NUM_REGS,
	parameter int ZF_INDEX    = bvm_pkg::DEF_ZF_INDEX,
	parameter int CF_INDEX    = bvm_pkg::DEF_CF_INDEX,
	parameter int OF_INDEX    = bvm_pkg::DEF_OF_INDEX,
	parameter int PC_INDEX    = bvm_pkg::DEF_PC_INDEX,
	parameter int STACK_DEPTH = bvm_pkg::DEF_STACK_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] func,
	input  logic [1:0] operand_kind,
	input  logic [7:0] first_operand,
	input  logic [7:0] second_operand,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic       print_valid,
	output logic [7:0] print_value,
	output logic [7:0] program_counter
);
	import bvm_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int SL_ZF = 0;
	localparam int SL_CF = 1;
	localparam int SL_OF = 2;
	localparam int SL_PC = 3;
	localparam logic [3:0][7:0] SLOT_IDX = {8'(PC_INDEX), 8'(OF_INDEX), 8'(CF_INDEX),
		8'(ZF_INDEX)};
	localparam logic [3:0] SLOT_ON = {PC_INDEX < NUM_REGS, OF_INDEX < NUM_REGS,
		CF_INDEX < NUM_REGS, ZF_INDEX < NUM_REGS};

	// handshake
	logic in_acc;
	logic out_free;
	logic s1_adv;
	logic s1_vld_q;
	logic out_vld_q;

	// accept-side decode
	logic             a_ok;
	logic             b_ok;
	status_t          st_in;
	logic             push_ok;
	logic             pop_ok;
	logic [CNT_W-1:0] cnt_q;
	byte_t            pop_addr;

	// stage 1
	logic [3:0] func_s1;
	logic [1:0] kind_s1;
	byte_t      a_s1;
	byte_t      b_s1;
	status_t    st_s1;
	byte_t      sp_s1;
	byte_t      pop_addr_s1;
	wr_port_t   rf_fwd_s1;
	wr_port_t   sk_fwd_s1;

	// execute
	byte_t           ra;
	byte_t           rb;
	byte_t           sk_rdata;
	byte_t           x_mem;
	byte_t           y_mem;
	byte_t           x;
	byte_t           y_reg;
	byte_t           y;
	byte_t           t;
	byte_t           pop_val;
	alu_out_t        alu;
	logic            dest_we;
	byte_t           dest_val;
	logic            flag_we;
	logic            pc_we;
	logic            push_we;
	logic            pv;
	byte_t           pval;
	logic [3:0][7:0] slot_q;
	logic [3:0][7:0] slot_nx;
	wr_port_t        rf_wr;
	wr_port_t        sk_wr;

	// output register
	status_t st_q;
	logic    pv_q;
	byte_t   pval_q;
	byte_t   pc_q;

	function automatic byte_t slot_rd(byte_t addr, byte_t memval, logic [3:0][7:0] sl);
		byte_t v;
		v = memval;
		for (int k = 0; k < 4; k++) begin
			if (SLOT_ON[k] && addr == SLOT_IDX[k]) begin
				v = sl[k];
			end
		end
		return v;
	endfunction

	assign out_free = !out_vld_q || !out_stall;
	assign s1_adv   = s1_vld_q && out_free;
	assign in_stall = s1_vld_q && !out_free;
	assign in_acc   = in_valid && !in_stall;

	assign a_ok     = ({1'b0, first_operand} < 9'(NUM_REGS));
	assign b_ok     = ({1'b0, second_operand} < 9'(NUM_REGS));
	assign pop_addr = 8'(cnt_q - 1'b1);

	always_comb begin
		st_in = ST_OK;
		unique case (func) inside
			OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_CMP: begin
				if (operand_kind == KD_REG || operand_kind == KD_IMM) begin
					st_in = ST_KIND;
				end else if (!a_ok || (operand_kind == KD_RR && !b_ok)) begin
					st_in = ST_REG;
				end
			end
			OP_POP: begin
				if (operand_kind != KD_REG) begin
					st_in = ST_KIND;
				end else if (!a_ok) begin
					st_in = ST_REG;
				end else if (cnt_q == '0) begin
					st_in = ST_EMPTY;
				end
			end
			OP_PUSH, OP_JMP, OP_BE, OP_BNE, OP_PRINT: begin
				if (operand_kind == KD_RR || operand_kind == KD_RI) begin
					st_in = ST_KIND;
				end else if (operand_kind == KD_REG && !a_ok) begin
					st_in = ST_REG;
				end else if (func == OP_PUSH && cnt_q >= CNT_W'(STACK_DEPTH)) begin
					st_in = ST_FULL;
				end
			end
			default: ;
		endcase
	end

	assign push_ok = (func == OP_PUSH) && (st_in == ST_OK);
	assign pop_ok  = (func == OP_POP) && (st_in == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && push_ok) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (in_acc && pop_ok) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// writes landing at the accept edge are kept for forwarding
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1     <= func;
			kind_s1     <= operand_kind;
			a_s1        <= first_operand;
			b_s1        <= second_operand;
			st_s1       <= st_in;
			sp_s1       <= 8'(cnt_q);
			pop_addr_s1 <= pop_addr;
			rf_fwd_s1   <= rf_wr;
			sk_fwd_s1   <= sk_wr;
		end
	end

	bvm_regfile #(
		.NUM_REGS (NUM_REGS)
	) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.raddr_a (first_operand),
		.raddr_b (second_operand),
		.wr      (rf_wr),
		.rdata_a (ra),
		.rdata_b (rb)
	);

	bvm_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.rd_en (in_acc && pop_ok),
		.raddr (pop_addr),
		.wr    (sk_wr),
		.rdata (sk_rdata)
	);

	always_comb begin
		x_mem   = (rf_fwd_s1.we && rf_fwd_s1.addr == a_s1) ? rf_fwd_s1.data : ra;
		y_mem   = (rf_fwd_s1.we && rf_fwd_s1.addr == b_s1) ? rf_fwd_s1.data : rb;
		x       = slot_rd(a_s1, x_mem, slot_q);
		y_reg   = slot_rd(b_s1, y_mem, slot_q);
		y       = (kind_s1 == KD_RR) ? y_reg : b_s1;
		t       = (kind_s1 == KD_REG) ? x : a_s1;
		pop_val = (sk_fwd_s1.we && sk_fwd_s1.addr == pop_addr_s1) ? sk_fwd_s1.data : sk_rdata;
	end

	bvm_alu u_alu (
		.func (func_s1),
		.x    (x),
		.y    (y),
		.res  (alu)
	);

	always_comb begin
		dest_we  = 1'b0;
		dest_val = alu.res;
		flag_we  = 1'b0;
		pc_we    = 1'b0;
		push_we  = 1'b0;
		pv       = 1'b0;
		pval     = 8'd0;
		if (st_s1 == ST_OK) begin
			unique case (func_s1) inside
				OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_CMP: begin
					dest_we = alu.dest_we;
					flag_we = alu.flag_we;
				end
				OP_POP: begin
					dest_we  = 1'b1;
					dest_val = pop_val;
				end
				OP_PUSH:  push_we = 1'b1;
				OP_JMP:   pc_we   = 1'b1;
				OP_BE:    pc_we   = (slot_q[SL_ZF] == 8'd1);
				OP_BNE:   pc_we   = (slot_q[SL_ZF] != 8'd1);
				OP_PRINT: begin
					pv   = 1'b1;
					pval = t;
				end
				default: ;
			endcase
		end
	end

	// flag writes follow the destination write
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			slot_nx[k] = slot_q[k];
			if (SLOT_ON[k]) begin
				if (dest_we && a_s1 == SLOT_IDX[k]) begin
					slot_nx[k] = dest_val;
				end
				if (pc_we && SLOT_IDX[SL_PC] == SLOT_IDX[k]) begin
					slot_nx[k] = t;
				end
				if (flag_we && SLOT_IDX[SL_ZF] == SLOT_IDX[k]) begin
					slot_nx[k] = {7'd0, alu.zf};
				end
				if (flag_we && SLOT_IDX[SL_CF] == SLOT_IDX[k]) begin
					slot_nx[k] = {7'd0, alu.cf};
				end
				if (flag_we && SLOT_IDX[SL_OF] == SLOT_IDX[k]) begin
					slot_nx[k] = {7'd0, alu.of};
				end
			end
		end
	end

	assign rf_wr = '{we: s1_adv && dest_we, addr: a_s1, data: dest_val};
	assign sk_wr = '{we: s1_adv && push_we, addr: sp_s1, data: t};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (s1_adv) begin
			slot_q <= slot_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			st_q   <= st_s1;
			pv_q   <= pv;
			pval_q <= pval;
			pc_q   <= slot_nx[SL_PC];
		end
	end

	assign out_valid       = out_vld_q;
	assign status          = st_q;
	assign print_valid     = pv_q;
	assign print_value     = pval_q;
	assign program_counter = pc_q;

endmodule

[rtl/core/bvm_checker.sv]
`include "assert_macros.svh"

module bvm_assert_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic       print_valid,
	input logic [7:0] print_value,
	input logic [7:0] program_counter
);
	import bvm_pkg::*;

	// stalled word holds
	`BVM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(print_valid) && $stable(print_value) && $stable(program_counter))

	// an accepted word must be followed by out_valid on the output
	`BVM_ASSERT(a_acc_to_out, in_valid && !in_stall |-> ##2 out_valid)

	`BVM_ASSERT(a_print_ok, out_valid && print_valid |-> status == ST_OK)

	`BVM_ASSERT(a_print_zero, out_valid && !print_valid |-> print_value == 8'd0)

endmodule

bind byte_vm_instruction_execute_core bvm_assert_checker u_bvm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.print_valid     (print_valid),
	.print_value     (print_value),
	.program_counter (program_counter)
);
